// File: design/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel swerve kinematics package
// Shared widths, constants, the arctangent table and the beat types that run
// between the front end, the CORDIC cells and the back end.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Input word width and CORDIC iteration count.
  localparam int VelWidth     = 16;
  localparam int CordicStages = 16;
  localparam int NumWheels    = 3;

  // Arctangent table length and the index width that addresses it.
  localparam int TabLen        = 24;
  localparam int StageIdxWidth = $clog2(TabLen);

  // Wheel components in Q.16 need eight fraction bits plus one bit of growth.
  localparam int CompWidth  = VelWidth + 9;
  // CORDIC gain times sqrt(2) stays below four, so two more bits.
  localparam int CordWidth  = CompWidth + 2;
  localparam int AngWidth   = 32;
  localparam int GainWidth  = 16;
  localparam int SinWidth   = 16;
  localparam int HWidth     = VelWidth + SinWidth + 2;
  localparam int ProdWidth  = CordWidth - 1 + GainWidth;
  localparam int SpeedWidth = 17;
  localparam int SteerWidth = 13;
  localparam int SteerProdWidth = AngWidth + SteerWidth;

  // Output buffer depth.
  localparam int FifoDepth  = 2;
  localparam int PtrWidth   = $clog2(FifoDepth);
  localparam int CntWidth   = $clog2(FifoDepth + 1);

  // sqrt(3)/2 and the inverse CORDIC gain, both in Q0.16.
  localparam logic [SinWidth-1:0]   Sin60   = 16'd56756;
  localparam logic [GainWidth-1:0]  InvGain = 16'd39797;
  localparam logic [SpeedWidth-1:0] SpeedMax = 17'h1FFFF;

  // Binary angles for the four axis directions (2^32 is a full turn).
  localparam logic [AngWidth-1:0] Ang0   = 32'h0000_0000;
  localparam logic [AngWidth-1:0] Ang90  = 32'h4000_0000;
  localparam logic [AngWidth-1:0] Ang180 = 32'h8000_0000;
  localparam logic [AngWidth-1:0] Ang270 = 32'hC000_0000;

  // atan(2^-i) as a binary angle, rounded to nearest.
  localparam logic [AngWidth-1:0] AtanTab [TabLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One wheel vector in flight. Bypass marks an axis or zero vector whose
  // magnitude and angle are already final.
  typedef struct packed {
    logic [CordWidth-1:0] x;
    logic [CordWidth-1:0] y;
    logic [AngWidth-1:0]  z;
    logic                 bypass;
  } vec_t;

  typedef struct packed {
    logic                       valid;
    vec_t [NumWheels-1:0]       vec;
  } cell_t;

  typedef struct packed {
    logic [NumWheels-1:0][SpeedWidth-1:0] speed;
    logic [NumWheels-1:0][SteerWidth-1:0] steer;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// File: design/three_wheel_swerve_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel swerve drive inverse kinematics
// Turns one chassis velocity command into drive speed and steering count for
// three wheels spaced 120 degrees apart.
// ----------------------------------------------------------------------------
// The block takes one command beat (vel_x, vel_y, vel_omega, signed Q7.8) in
// every clock cycle while in_ready_o is high and returns one result beat per
// command, in order: for each wheel the speed magnitude in Q9.8, saturated
// at 131071, and the steering angle counterclockwise from +x as
// round(angle/360*8191). A zero wheel vector gives speed 0 and steering 0;
// a vector on an axis gets its exact angle. A command passes through three
// front-end stages, one CORDIC cell per iteration, three back-end stages
// and the output buffer. The throughput is one beat per cycle while the
// output buffer has room, set by the single register stage that each cell
// adds. A two-beat output buffer parts the pipeline from the consumer, so
// in_ready_o comes from a register and stays high while the buffer holds a
// free slot.
// ----------------------------------------------------------------------------
module three_wheel_swerve_kinematics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tws_pkg::VelWidth-1:0]   vel_x_i,
  input  logic signed [tws_pkg::VelWidth-1:0]   vel_y_i,
  input  logic signed [tws_pkg::VelWidth-1:0]   vel_omega_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tws_pkg::SpeedWidth-1:0]        speed_wheel0_o,
  output logic [tws_pkg::SpeedWidth-1:0]        speed_wheel1_o,
  output logic [tws_pkg::SpeedWidth-1:0]        speed_wheel2_o,
  output logic [tws_pkg::SteerWidth-1:0]        steer_wheel0_o,
  output logic [tws_pkg::SteerWidth-1:0]        steer_wheel1_o,
  output logic [tws_pkg::SteerWidth-1:0]        steer_wheel2_o
);

  localparam int NS = tws_pkg::CordicStages;

  // The whole pipeline moves as one while the output buffer has room.
  logic                          en;
  logic                          wr, rd;
  logic [tws_pkg::CntWidth-1:0]  cnt_q, cnt_d;
  logic [tws_pkg::PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  tws_pkg::out_t                 fifo_q [tws_pkg::FifoDepth];

  tws_pkg::cell_t chain [NS+1];
  tws_pkg::res_t  post_q;

  assign en = (cnt_q != tws_pkg::CntWidth'(tws_pkg::FifoDepth));

  // Front end: wheel components, half-plane fold and axis detection.
  tws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .vel_omega_i (vel_omega_i),
    .q_o         (chain[0])
  );

  // Row of CORDIC cells; cell g shifts by g and adds or subtracts atan(2^-g).
  for (genvar g = 0; g < NS; g++) begin : g_cell
    tws_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (tws_pkg::StageIdxWidth'(g)),
      .angle_i (tws_pkg::AtanTab[g]),
      .d_i     (chain[g]),
      .q_o     (chain[g+1])
    );
  end

  // Back end: gain removal, rounding, saturation and the steering count.
  tws_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (chain[NS]),
    .q_o    (post_q)
  );

  // Output buffer. A beat leaving the back end always finds a free slot,
  // because the pipeline only advances while the buffer is not full.
  assign wr    = en && post_q.valid;
  assign rd    = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + tws_pkg::CntWidth'(wr) - tws_pkg::CntWidth'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      fifo_q[wr_ptr_q] <= post_q.data;
    end
  end

  assign in_ready_o     = en;
  assign out_valid_o    = (cnt_q != '0);
  assign speed_wheel0_o = fifo_q[rd_ptr_q].speed[0];
  assign speed_wheel1_o = fifo_q[rd_ptr_q].speed[1];
  assign speed_wheel2_o = fifo_q[rd_ptr_q].speed[2];
  assign steer_wheel0_o = fifo_q[rd_ptr_q].steer[0];
  assign steer_wheel1_o = fifo_q[rd_ptr_q].steer[1];
  assign steer_wheel2_o = fifo_q[rd_ptr_q].steer[2];

  // The buffer never holds more beats than it has slots.
  ap_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tws_pkg::CntWidth'(tws_pkg::FifoDepth))
    else $error("output buffer count out of range");

  // The count follows writes and reads exactly.
  ap_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + tws_pkg::CntWidth'($past(wr))
                      - tws_pkg::CntWidth'($past(rd)))
    else $error("output buffer count lost track");

  // A result appears only after the back end handed one over.
  ap_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(wr))
    else $error("output valid without a buffer write");

  // The pointers differ by the count modulo the depth; this checks the empty case, where they are equal.
  ap_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty buffer with pointers apart");

endmodule

// File: design/tws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve kinematics front end
// Splits the chassis command into three wheel vectors and prepares each one
// for the CORDIC cells (half-plane fold and axis detection).
// ----------------------------------------------------------------------------
module tws_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [tws_pkg::VelWidth-1:0] vel_x_i,
  input  logic signed [tws_pkg::VelWidth-1:0] vel_y_i,
  input  logic signed [tws_pkg::VelWidth-1:0] vel_omega_i,
  output tws_pkg::cell_t                      q_o
);

  localparam int VW = tws_pkg::VelWidth;
  localparam int CW = tws_pkg::CompWidth;
  localparam int RW = tws_pkg::CordWidth;
  localparam int HW = tws_pkg::HWidth;

  // Stage 1: register the command and omega * sin(60).
  logic                 s1_valid_q;
  logic signed [VW-1:0] s1_vx_q, s1_vy_q, s1_om_q;
  logic signed [HW-1:0] s1_h_q, s1_h_d;

  assign s1_h_d = vel_omega_i * $signed({2'b00, tws_pkg::Sin60});

  // Stage 2: wheel components in Q.16.
  logic                 s2_valid_q;
  logic signed [CW-1:0] s2_wx_q [tws_pkg::NumWheels];
  logic signed [CW-1:0] s2_wy_q [tws_pkg::NumWheels];
  logic signed [CW-1:0] vx_s, vy_s, w_s, half_s, h_s;
  logic signed [HW-1:0] h_sum, h_shr;

  assign vx_s   = $signed({{(CW-VW-8){s1_vx_q[VW-1]}}, s1_vx_q, 8'b0});
  assign vy_s   = $signed({{(CW-VW-8){s1_vy_q[VW-1]}}, s1_vy_q, 8'b0});
  assign w_s    = $signed({{(CW-VW-8){s1_om_q[VW-1]}}, s1_om_q, 8'b0});
  assign half_s = $signed({{(CW-VW-7){s1_om_q[VW-1]}}, s1_om_q, 7'b0});
  assign h_sum  = s1_h_q + $signed(HW'(128));
  assign h_shr  = h_sum >>> 8;
  assign h_s    = $signed(h_shr[CW-1:0]);

  // Stage 3: per-wheel preparation.
  tws_pkg::cell_t s3_q, s3_d;

  always_comb begin
    logic signed [RW-1:0] xe, ye;
    s3_d.valid = s2_valid_q;
    for (int k = 0; k < tws_pkg::NumWheels; k++) begin
      xe = RW'(s2_wx_q[k]);
      ye = RW'(s2_wy_q[k]);
      s3_d.vec[k].y      = '0;
      s3_d.vec[k].bypass = 1'b1;
      if (ye == '0) begin
        s3_d.vec[k].x = (xe < 0) ? -xe : xe;
        s3_d.vec[k].z = (xe < 0) ? tws_pkg::Ang180 : tws_pkg::Ang0;
      end else if (xe == '0) begin
        s3_d.vec[k].x = (ye < 0) ? -ye : ye;
        s3_d.vec[k].z = (ye < 0) ? tws_pkg::Ang270 : tws_pkg::Ang90;
      end else begin
        s3_d.vec[k].bypass = 1'b0;
        if (xe < 0) begin
          s3_d.vec[k].x = -xe;
          s3_d.vec[k].y = -ye;
          s3_d.vec[k].z = tws_pkg::Ang180;
        end else begin
          s3_d.vec[k].x = xe;
          s3_d.vec[k].y = ye;
          s3_d.vec[k].z = tws_pkg::Ang0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_q       <= '0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_q       <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_vx_q    <= vel_x_i;
      s1_vy_q    <= vel_y_i;
      s1_om_q    <= vel_omega_i;
      s1_h_q     <= s1_h_d;
      s2_wx_q[0] <= vx_s - w_s;
      s2_wy_q[0] <= vy_s;
      s2_wx_q[1] <= vx_s + half_s;
      s2_wy_q[1] <= vy_s - h_s;
      s2_wx_q[2] <= vx_s + half_s;
      s2_wy_q[2] <= vy_s + h_s;
    end
  end

  assign q_o = s3_q;

endmodule

// File: design/tws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve kinematics CORDIC cell
// One vectoring iteration for all three wheel vectors, registered.
// ----------------------------------------------------------------------------
module tws_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [tws_pkg::StageIdxWidth-1:0]    shift_i,
  input  logic [tws_pkg::AngWidth-1:0]         angle_i,
  input  tws_pkg::cell_t                       d_i,
  output tws_pkg::cell_t                       q_o
);

  localparam int RW = tws_pkg::CordWidth;

  tws_pkg::cell_t q_q, q_d;

  always_comb begin
    logic signed [RW-1:0] x, y, dx, dy;
    q_d = d_i;
    for (int k = 0; k < tws_pkg::NumWheels; k++) begin
      x  = $signed(d_i.vec[k].x);
      y  = $signed(d_i.vec[k].y);
      dx = y >>> shift_i;
      dy = x >>> shift_i;
      if (!d_i.vec[k].bypass) begin
        // Rotate toward the x axis; the sign of y picks the direction.
        if (y < 0) begin
          q_d.vec[k].x = x - dx;
          q_d.vec[k].y = y + dy;
          q_d.vec[k].z = d_i.vec[k].z - angle_i;
        end else begin
          q_d.vec[k].x = x + dx;
          q_d.vec[k].y = y - dy;
          q_d.vec[k].z = d_i.vec[k].z + angle_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: design/tws_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve kinematics back end
// Removes the CORDIC gain, rounds and saturates the speed, and converts the
// binary angle to a steering encoder count.
// ----------------------------------------------------------------------------
module tws_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  tws_pkg::cell_t d_i,
  output tws_pkg::res_t  q_o
);

  localparam int NW  = tws_pkg::NumWheels;
  localparam int RW  = tws_pkg::CordWidth;
  localparam int PW  = tws_pkg::ProdWidth;
  localparam int GW  = tws_pkg::GainWidth;
  localparam int AW  = tws_pkg::AngWidth;
  localparam int SW  = tws_pkg::SteerWidth;
  localparam int SPW = tws_pkg::SteerProdWidth;
  localparam int MW  = PW + 1 - GW;
  localparam int QW  = MW + 1 - 8;
  localparam int TW  = (QW > tws_pkg::SpeedWidth) ? QW : tws_pkg::SpeedWidth;

  // Stage 1: gain multiply and angle times 8191.
  logic          p1_valid_q;
  logic [PW-1:0]  p1_mag_q  [NW];
  logic [SPW-1:0] p1_ang_q  [NW];
  logic [PW-1:0]  p1_mag_d  [NW];
  logic [SPW-1:0] p1_ang_d  [NW];

  always_comb begin
    logic [RW-2:0] m;
    for (int k = 0; k < NW; k++) begin
      m = d_i.vec[k].x[RW-1] ? '0 : d_i.vec[k].x[RW-2:0];
      // An axis vector carries its exact magnitude, so it only moves into Q.32.
      p1_mag_d[k] = d_i.vec[k].bypass ? {m, {GW{1'b0}}}
                                      : PW'(m) * PW'(tws_pkg::InvGain);
      p1_ang_d[k] = {d_i.vec[k].z, {SW{1'b0}}} - SPW'(d_i.vec[k].z);
    end
  end

  // Stage 2: round the magnitude to Q.16 and the angle count to an integer.
  logic          p2_valid_q;
  logic [MW-1:0] p2_mag_q   [NW];
  logic [SW-1:0] p2_steer_q [NW];
  logic [MW-1:0] p2_mag_d   [NW];
  logic [SW-1:0] p2_steer_d [NW];

  always_comb begin
    logic [PW:0]  msum;
    logic [SPW:0] asum;
    for (int k = 0; k < NW; k++) begin
      msum = {1'b0, p1_mag_q[k]} + ((PW + 1)'(1) << (GW - 1));
      asum = {1'b0, p1_ang_q[k]} + ((SPW + 1)'(1) << (AW - 1));
      p2_mag_d[k]   = msum[PW:GW];
      p2_steer_d[k] = asum[AW+SW-1:AW];
    end
  end

  // Stage 3: round to Q9.8 and saturate.
  tws_pkg::res_t p3_q, p3_d;

  always_comb begin
    logic [MW:0]   ssum;
    logic [TW-1:0] spd;
    p3_d.valid = p2_valid_q;
    for (int k = 0; k < NW; k++) begin
      ssum = {1'b0, p2_mag_q[k]} + (MW + 1)'(128);
      spd  = TW'(ssum[MW:8]);
      p3_d.data.speed[k] = (spd > TW'(tws_pkg::SpeedMax)) ? tws_pkg::SpeedMax
                                                         : spd[tws_pkg::SpeedWidth-1:0];
      p3_d.data.steer[k] = p2_steer_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_q       <= '0;
    end else if (en_i) begin
      p1_valid_q <= d_i.valid;
      p2_valid_q <= p1_valid_q;
      p3_q       <= p3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_mag_q   <= p1_mag_d;
      p1_ang_q   <= p1_ang_d;
      p2_mag_q   <= p2_mag_d;
      p2_steer_q <= p2_steer_d;
    end
  end

  assign q_o = p3_q;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel swerve kinematics testbench
// Drives chassis velocity commands through the valid/ready input channel,
// predicts each wheel's speed and steering count, and checks every result
// beat against the prediction in order while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  import tws_pkg::*;

  // Generous run limit in clock cycles; a correct run needs far fewer.
  localparam int unsigned CycleLimit = 400000;
  // Pipeline latency with sixteen CORDIC cells, plus some margin.
  localparam int unsigned DrainCycles = CordicStages + 6 + 20;
  localparam int unsigned RandomCmds = 1500;
  localparam int unsigned ReportMax = 10;

  typedef logic signed [VelWidth-1:0] vel_t;

  // One pending command. When hold is set, the driver waits until every
  // predicted result has come back before it presents this command.
  typedef struct {
    vel_t vx;
    vel_t vy;
    vel_t om;
    bit   hold;
  } chassis_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  vel_t vel_x_i = '0;
  vel_t vel_y_i = '0;
  vel_t vel_omega_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SpeedWidth-1:0] speed_wheel0_o, speed_wheel1_o, speed_wheel2_o;
  logic [SteerWidth-1:0] steer_wheel0_o, steer_wheel1_o, steer_wheel2_o;

  chassis_cmd_t cmd_q[$];
  out_t wheel_q[$];

  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic cmd_fire = 1'b0;

  // Sender burst state and receiver stall state.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  logic [15:0] rx_pattern = '0;

  three_wheel_swerve_kinematics uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vel_x_i        (vel_x_i),
    .vel_y_i        (vel_y_i),
    .vel_omega_i    (vel_omega_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .speed_wheel0_o (speed_wheel0_o),
    .speed_wheel1_o (speed_wheel1_o),
    .speed_wheel2_o (speed_wheel2_o),
    .steer_wheel0_o (steer_wheel0_o),
    .steer_wheel1_o (steer_wheel1_o),
    .steer_wheel2_o (steer_wheel2_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Converts one wheel vector (Q.16 components) to a speed in Q9.8 and a
  // steering count. Axis and zero vectors skip the CORDIC and get exact
  // angles; everything else is folded into the right half-plane first and
  // then rotated onto the x axis, one fixed arctangent step per stage.
  function automatic void wheel_polar(input longint x_in, input longint y_in,
                                      output logic [SpeedWidth-1:0] speed,
                                      output logic [SteerWidth-1:0] steer);
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint mag;
    longint spd;
    logic [AngWidth-1:0] ang;
    logic [63:0] count;
    x = x_in;
    y = y_in;
    ang = Ang0;
    if (x == 0 && y == 0) begin
      speed = '0;
      steer = '0;
      return;
    end
    if (y == 0) begin
      mag = (x < 0) ? -x : x;
      ang = (x < 0) ? Ang180 : Ang0;
    end else if (x == 0) begin
      mag = (y < 0) ? -y : y;
      ang = (y < 0) ? Ang270 : Ang90;
    end else begin
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = Ang180;
      end
      for (int i = 0; i < CordicStages && i < TabLen; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x = x - dx;
          y = y + dy;
          ang = ang - AtanTab[i];
        end else begin
          x = x + dx;
          y = y - dy;
          ang = ang + AtanTab[i];
        end
      end
      mag = (x < 0) ? 0 : x;
      mag = (mag * longint'(InvGain) + 64'sd32768) >>> 16;
    end
    spd = (mag + 128) >>> 8;
    if (spd > longint'(SpeedMax)) spd = longint'(SpeedMax);
    speed = spd[SpeedWidth-1:0];
    // Scale the binary angle to the 0..8191 encoder range, rounded to nearest.
    count = {32'b0, ang} * 64'd8191 + 64'h8000_0000;
    steer = count[32 +: SteerWidth];
  endfunction

  // Splits the chassis command into the three wheel vectors and solves each.
  function automatic out_t solve_wheels(input vel_t vx, input vel_t vy,
                                        input vel_t om);
    out_t res;
    longint cx;
    longint cy;
    longint rot;
    longint half;
    longint h;
    longint wx[NumWheels];
    longint wy[NumWheels];
    cx = longint'(vx) * 256;
    cy = longint'(vy) * 256;
    rot = longint'(om) * 256;
    half = longint'(om) * 128;
    // Rotation times sin(60), rounded half up in Q.16.
    h = (longint'(om) * longint'(Sin60) + 128) >>> 8;
    wx[0] = cx - rot;
    wy[0] = cy;
    wx[1] = cx + half;
    wy[1] = cy - h;
    wx[2] = cx + half;
    wy[2] = cy + h;
    for (int k = 0; k < NumWheels; k++) begin
      wheel_polar(wx[k], wy[k], res.speed[k], res.steer[k]);
    end
    return res;
  endfunction

  task automatic push_cmd(input int vx, input int vy, input int om,
                          input bit hold = 1'b0);
    chassis_cmd_t c;
    c.vx = vel_t'(vx);
    c.vy = vel_t'(vy);
    c.om = vel_t'(om);
    c.hold = hold;
    cmd_q.push_back(c);
  endtask

  // Random command with a bias toward the interesting corners: most are
  // full-range, the rest are tiny values, zeros that put wheels on an axis,
  // and the range extremes.
  function automatic chassis_cmd_t random_cmd();
    chassis_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.vx = vel_t'($urandom);
    c.vy = vel_t'($urandom);
    c.om = vel_t'($urandom);
    c.hold = 1'b0;
    if (pick < 15) begin
      c.vx = vel_t'($urandom_range(0, 32) - 16);
      c.vy = vel_t'($urandom_range(0, 32) - 16);
      c.om = vel_t'($urandom_range(0, 32) - 16);
    end else if (pick < 22) begin
      // Wheel 0 lands on an axis or at zero.
      c.vx = c.om;
      if ($urandom_range(0, 1) == 0) c.vy = '0;
    end else if (pick < 30) begin
      if ($urandom_range(0, 1) == 0) c.vx = '0;
      if ($urandom_range(0, 1) == 0) c.vy = '0;
      if ($urandom_range(0, 1) == 0) c.om = '0;
    end else if (pick < 36) begin
      c.vx = $urandom_range(0, 1) ? vel_t'(16'h7FFF) : vel_t'(16'h8000);
      c.vy = $urandom_range(0, 1) ? vel_t'(16'h7FFF) : vel_t'(16'h8000);
      c.om = $urandom_range(0, 1) ? vel_t'(16'h7FFF) : vel_t'(16'h8000);
    end
    return c;
  endfunction

  // Sender: inputs change on the falling edge. A new command is loaded only
  // once the current beat has been taken, so valid and the payload hold
  // steady while the block stalls. Bursts of random length alternate with
  // random gaps, and a gap of zero gives long back-to-back stretches.
  always @(negedge clk_i) begin
    chassis_cmd_t nxt;
    logic send;
    if (rst_ni) begin
      if (!in_valid_i || cmd_fire) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].hold && wheel_q.size() != 0)) begin
          nxt = cmd_q.pop_front();
          send = 1'b1;
          vel_x_i <= nxt.vx;
          vel_y_i <= nxt.vy;
          vel_omega_i <= nxt.om;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 3))
              0, 2: gap_left = 0;
              1: gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 20);
            endcase
          end else begin
            burst_left--;
          end
        end
        in_valid_i <= send;
      end

      // Receiver: switches between always ready, light stalls, a rotating
      // bit pattern and heavy stalls, each for a random stretch.
      if (rx_left == 0) begin
        rx_left = $urandom_range(20, 200);
        rx_mode = $urandom_range(0, 3);
        rx_pattern = 16'($urandom);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: begin
          out_ready_i <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: samples both channels on the rising edge. Every accepted
  // command beat adds one predicted result; every accepted result beat is
  // checked against the oldest prediction, wheel by wheel.
  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, wheel_q.size());
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni) begin
      cmd_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        wheel_q.push_back(solve_wheels(vel_x_i, vel_y_i, vel_omega_i));
      end
      if (out_valid_o && out_ready_i) begin
        got.speed[0] = speed_wheel0_o;
        got.speed[1] = speed_wheel1_o;
        got.speed[2] = speed_wheel2_o;
        got.steer[0] = steer_wheel0_o;
        got.steer[1] = steer_wheel1_o;
        got.steer[2] = steer_wheel2_o;
        if (wheel_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= ReportMax) begin
            $display("%0t: result beat with no command pending", $realtime);
          end
        end else begin
          want = wheel_q.pop_front();
          for (int k = 0; k < NumWheels; k++) begin
            if (got.speed[k] !== want.speed[k]) begin
              fault_cnt++;
              if (fault_cnt <= ReportMax) begin
                $display("%0t: wheel %0d speed expected %0d, actual %0d",
                         $realtime, k, want.speed[k], got.speed[k]);
              end
            end
            if (got.steer[k] !== want.steer[k]) begin
              fault_cnt++;
              if (fault_cnt <= ReportMax) begin
                $display("%0t: wheel %0d steer expected %0d, actual %0d",
                         $realtime, k, want.steer[k], got.steer[k]);
              end
            end
          end
        end
      end
    end
  end

  initial begin
    chassis_cmd_t c;

    // Directed commands: standstill, each axis direction, range extremes,
    // pure rotation, a zero vector on wheel 0 only, a vector just below
    // the positive x axis (the count rounds up to the top of the range),
    // and vectors in the left half-plane.
    push_cmd(0, 0, 0);
    push_cmd(100, 0, 0);
    push_cmd(-100, 0, 0);
    push_cmd(0, 100, 0);
    push_cmd(0, -100, 0);
    push_cmd(1, 0, 0);
    push_cmd(0, 1, 0);
    push_cmd(0, 0, 1);
    push_cmd(0, 0, -1);
    push_cmd(0, 0, 32767);
    push_cmd(0, 0, -32768);
    push_cmd(32767, 32767, 32767);
    push_cmd(-32768, -32768, -32768);
    push_cmd(32767, -32768, 0);
    push_cmd(-32768, 32767, 32767);
    push_cmd(32767, 0, -32768);
    push_cmd(-32768, 0, 32767);
    push_cmd(50, 0, 50);
    push_cmd(-7, 0, -7);
    push_cmd(32767, -1, 0);
    push_cmd(1000, -1, 0);
    push_cmd(-300, 200, 50);
    push_cmd(-300, -200, -50);
    push_cmd(-1, 1, 0);

    for (int n = 0; n < RandomCmds; n++) begin
      c = random_cmd();
      // Let the pipeline run dry now and then before the next command.
      c.hold = (n % 400 == 0);
      cmd_q.push_back(c);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || wheel_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fault_cnt == 0 && wheel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
